FILE: sv/mdps_pkg.sv
// Shared types and constants of the multichannel delayed pulse sequencer.
package mdps_pkg;

	// Channel count; the width of the trigger line field follows from it
	localparam int unsigned CHANNELS = 16;
	localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned TIME_W   = 16;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_PULSE_TICKS = 15;
	localparam int unsigned DEF_BASE_DELAY  = 100;
	localparam int unsigned DEF_CHAIN_TICKS = 1500;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_EXT_TRIG = 3'd1,
		CMD_START    = 3'd2,
		CMD_STOP     = 3'd3,
		CMD_SET      = 3'd4,
		CMD_GET      = 3'd5
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_PORT = 2'd1,
		ST_IGNORED  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [7:0]        port;
		logic [TIME_W-1:0] delay_value;
	} cmd_item_t;

	typedef struct packed {
		logic [CHANNELS-1:0] trigger_lines;
		logic                chain_out;
		logic                running;
		status_t             status;
		logic [TIME_W-1:0]   read_value;
	} res_item_t;

	// Position write toward the channel table
	typedef struct packed {
		logic              en;
		logic [CH_W-1:0]   idx;
		logic [TIME_W-1:0] value;
	} set_req_t;

endpackage

FILE: sv/mdps_table.sv
// Channel table: stored positions, per-channel delay offsets and effective fire times.
module mdps_table #(
	parameter int unsigned BASE_DELAY = mdps_pkg::DEF_BASE_DELAY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mdps_pkg::set_req_t      set,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_data,
	input  logic [mdps_pkg::CH_W-1:0] rd_idx,
	output logic [15:0]             rd_pos,
	output logic [15:0]             eff [mdps_pkg::CHANNELS]
);
	import mdps_pkg::*;

	logic [TIME_W-1:0] pos_q [CHANNELS];
	logic [TIME_W-1:0] off_q [CHANNELS];
	logic [TIME_W-1:0] eff_q [CHANNELS];
	logic [TIME_W-1:0] new_pos;

	// Stored position for a set request
	assign new_pos = TIME_W'(BASE_DELAY) - set.value;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		logic [TIME_W-1:0] prod;

		// Offset of this channel for a new sequence delay
		assign prod = TIME_W'(32'(cfg_data) * i);

		// Hold position, offset and effective time; refresh on writes
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[i] <= TIME_W'(BASE_DELAY - 5 * i);
				off_q[i] <= '0;
				eff_q[i] <= TIME_W'(BASE_DELAY - 5 * i);
			end else if (cfg_we) begin
				off_q[i] <= prod;
				eff_q[i] <= pos_q[i] + prod;
			end else if (set.en && set.idx == CH_W'(i)) begin
				pos_q[i] <= new_pos;
				eff_q[i] <= new_pos + off_q[i];
			end
		end

		assign eff[i] = eff_q[i];
	end

	assign rd_pos = pos_q[rd_idx];

endmodule

FILE: sv/mdps_chan.sv
// Per-channel compare bank: line levels and run completion for one tick.
module mdps_chan #(
	parameter int unsigned PULSE_TICKS = mdps_pkg::DEF_PULSE_TICKS
) (
	input  logic [15:0]                   cnt,
	input  logic [15:0]                   eff [mdps_pkg::CHANNELS],
	input  logic [mdps_pkg::CHANNELS-1:0] lines_in,
	output logic [mdps_pkg::CHANNELS-1:0] lines_out,
	output logic                          all_done
);
	import mdps_pkg::*;

	logic [CHANNELS-1:0] pending;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		logic [TIME_W:0] stop_at;
		logic            armed;

		// Pulse end, taken without wrap
		assign stop_at = {1'b0, eff[i]} + (TIME_W+1)'(PULSE_TICKS);
		// A channel with effective time zero never fires
		assign armed   = (eff[i] != '0);

		// Drop the line at the fire time, raise it at the pulse end
		always_comb begin
			lines_out[i] = lines_in[i];
			if (armed && cnt == eff[i])
				lines_out[i] = 1'b0;
			if (armed && {1'b0, cnt} == stop_at)
				lines_out[i] = 1'b1;
		end

		assign pending[i] = armed && ({1'b0, cnt} < stop_at);
	end

	assign all_done = ~|pending;

endmodule

FILE: sv/multichannel_delayed_pulse_sequencer_unit.sv
// Top level of the multichannel delayed pulse sequencer.
// Takes one request per clock cycle unless the result side stalls, and returns one result
// for each: a request lands in an input register, then a single pass of sixteen
// parallel fire/end comparators and the table logic decides the new state and writes
// the result register. Effective fire times are kept precomputed in the channel table,
// so a set request or a sequence delay write is visible to the very next request.
// The sequence delay register is written through its own channel, which is always ready.
module multichannel_delayed_pulse_sequencer_unit #(
	parameter int unsigned PULSE_TICKS = mdps_pkg::DEF_PULSE_TICKS,
	parameter int unsigned BASE_DELAY  = mdps_pkg::DEF_BASE_DELAY,
	parameter int unsigned CHAIN_TICKS = mdps_pkg::DEF_CHAIN_TICKS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mdps_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output mdps_pkg::res_item_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_seq_delay
);
	import mdps_pkg::*;

	// Input stage
	logic      v_s1;
	cmd_item_t item_s1;
	logic      adv;

	// Sequencer state
	logic [TIME_W-1:0]   cnt_q,   cnt_d;
	logic                run_q,   run_d;
	logic [CHANNELS-1:0] lines_q, lines_d;
	logic                chain_q, chain_d;

	// Result stage
	logic      res_valid_q;
	res_item_t res_q, res_d;

	// Table and compare bank links
	set_req_t          set_req;
	logic [TIME_W-1:0] eff [CHANNELS];
	logic [TIME_W-1:0] rd_pos;
	logic [TIME_W-1:0] cnt_inc;
	logic [CHANNELS-1:0] tick_lines;
	logic              tick_done;
	logic              port_ok;

	assign cfg_ready = 1'b1;

	// Advance the input stage whenever the result register is free or being taken
	assign adv       = v_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !v_s1 || adv;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

	assign port_ok = (item_s1.port < 8'(CHANNELS));

	// Saturating count for the current tick
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + TIME_W'(1);

	mdps_table #(
		.BASE_DELAY(BASE_DELAY)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.set     (set_req),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_seq_delay),
		.rd_idx  (item_s1.port[CH_W-1:0]),
		.rd_pos  (rd_pos),
		.eff     (eff)
	);

	mdps_chan #(
		.PULSE_TICKS(PULSE_TICKS)
	) u_chan (
		.cnt      (cnt_inc),
		.eff      (eff),
		.lines_in (lines_q),
		.lines_out(tick_lines),
		.all_done (tick_done)
	);

	// Decode the request and form next state and result
	always_comb begin
		cnt_d   = cnt_q;
		run_d   = run_q;
		lines_d = lines_q;
		chain_d = chain_q;
		set_req = '{en: 1'b0, idx: item_s1.port[CH_W-1:0], value: item_s1.delay_value};
		res_d.status     = ST_OK;
		res_d.read_value = '0;
		case (item_s1.command)
			CMD_TICK: begin
				if (run_q) begin
					lines_d = tick_lines;
					if (tick_done) begin
						run_d = 1'b0;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_inc;
						if ({1'b0, cnt_inc} >= (TIME_W+1)'(CHAIN_TICKS))
							chain_d = 1'b0;
					end
				end
			end
			CMD_EXT_TRIG: begin
				if (run_q) begin
					res_d.status = ST_IGNORED;
				end else begin
					chain_d = 1'b1;
					cnt_d   = '0;
					run_d   = 1'b1;
				end
			end
			CMD_START: begin
				chain_d = 1'b1;
				cnt_d   = '0;
				run_d   = 1'b1;
			end
			CMD_STOP: begin
				run_d = 1'b0;
				cnt_d = '0;
			end
			CMD_SET: begin
				if (port_ok)
					set_req.en = adv;
				else
					res_d.status = ST_BAD_PORT;
			end
			CMD_GET: begin
				if (port_ok)
					res_d.read_value = rd_pos;
				else
					res_d.status = ST_BAD_PORT;
			end
			default: begin
			end
		endcase
		res_d.trigger_lines = lines_d;
		res_d.chain_out     = chain_d;
		res_d.running       = run_d;
	end

	// Commit state on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			run_q   <= 1'b0;
			lines_q <= '1;
			chain_q <= 1'b1;
		end else if (adv) begin
			cnt_q   <= cnt_d;
			run_q   <= run_d;
			lines_q <= lines_d;
			chain_q <= chain_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The count is cleared whenever no run is in progress
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> cnt_q == '0)
		else $error("tick count nonzero while idle");

	// The chain line only drops during a run past the chain tick
	a_chain_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(chain_q) |-> run_q && ({1'b0, cnt_q} >= (TIME_W+1)'(CHAIN_TICKS)))
		else $error("chain line dropped outside a run past the chain tick");

	// A rejected port never returns table data
	a_bad_port: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_BAD_PORT |-> res_q.read_value == '0)
		else $error("read value nonzero on invalid port");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the multichannel delayed pulse sequencer unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mdps_pkg::*;

	localparam int unsigned PULSE = DEF_PULSE_TICKS;
	localparam int unsigned BASE  = DEF_BASE_DELAY;
	localparam int unsigned CHAIN = DEF_CHAIN_TICKS;

	// Command codes with no defined action
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	// Directed table row: request plus an optional hand-written result
	typedef struct packed {
		cmd_item_t req;
		logic      known;
		res_item_t want;
	} dir_row_t;

	localparam res_item_t IDLE_OK  = '{16'hFFFF, 1'b1, 1'b0, ST_OK, 16'd0};
	localparam res_item_t RUN_OK   = '{16'hFFFF, 1'b1, 1'b1, ST_OK, 16'd0};
	localparam res_item_t IDLE_BAD = '{16'hFFFF, 1'b1, 1'b0, ST_BAD_PORT, 16'd0};

	localparam int NUM_DIRECTED = 22;
	localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{'{CMD_GET, 8'd0, 16'd0}, 1'b1, '{16'hFFFF, 1'b1, 1'b0, ST_OK, 16'd100}},
		'{'{CMD_GET, 8'd15, 16'hFFFF}, 1'b1, '{16'hFFFF, 1'b1, 1'b0, ST_OK, 16'd25}},
		'{'{CMD_GET, 8'd16, 16'd0}, 1'b1, IDLE_BAD},
		'{'{CMD_GET, 8'd255, 16'd0}, 1'b1, IDLE_BAD},
		'{'{CMD_SET, 8'd255, 16'hFFFF}, 1'b1, IDLE_BAD},
		'{'{CMD_SET, 8'd0, 16'd0}, 1'b1, IDLE_OK},
		'{'{CMD_SET, 8'd15, 16'hFFFF}, 1'b1, IDLE_OK},
		'{'{CMD_GET, 8'd15, 16'd0}, 1'b1, '{16'hFFFF, 1'b1, 1'b0, ST_OK, 16'd101}},
		'{'{CMD_TICK, 8'd0, 16'd0}, 1'b1, IDLE_OK},
		'{'{CMD_SPARE6, 8'hAA, 16'h5555}, 1'b1, IDLE_OK},
		'{'{CMD_SPARE7, 8'h55, 16'hAAAA}, 1'b1, IDLE_OK},
		'{'{CMD_SET, 8'd1, 16'd100}, 1'b1, IDLE_OK},
		'{'{CMD_EXT_TRIG, 8'd0, 16'd0}, 1'b1, RUN_OK},
		'{'{CMD_EXT_TRIG, 8'd0, 16'd0}, 1'b1, '{16'hFFFF, 1'b1, 1'b1, ST_IGNORED, 16'd0}},
		'{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, '0},
		'{'{CMD_START, 8'd0, 16'd0}, 1'b1, RUN_OK},
		'{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, '0},
		'{'{CMD_GET, 8'd3, 16'd0}, 1'b0, '0},
		'{'{CMD_STOP, 8'd0, 16'd0}, 1'b1, IDLE_OK},
		'{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, '0},
		'{'{CMD_START, 8'd0, 16'd0}, 1'b1, RUN_OK},
		'{'{CMD_STOP, 8'd0, 16'd0}, 1'b1, IDLE_OK}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_item_t   cmd = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_item_t   res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_seq_delay = '0;

	multichannel_delayed_pulse_sequencer_unit #(
		.PULSE_TICKS(PULSE),
		.BASE_DELAY (BASE),
		.CHAIN_TICKS(CHAIN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_seq_delay(cfg_seq_delay)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard
	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Sequencer state as predicted from the accepted requests
	logic [15:0] pos_tab [CHANNELS];
	logic [15:0] tick_cnt   = '0;
	logic [15:0] delay_step = '0;
	logic [15:0] line_lvl   = '1;
	logic        run_on     = 1'b0;
	logic        chain_lvl  = 1'b1;

	res_item_t   awaited_results [$];
	int unsigned mismatch_count = 0;
	int unsigned results_seen   = 0;
	int unsigned sent_count     = 0;
	int unsigned burst_left     = 0;

	initial begin
		for (int i = 0; i < CHANNELS; i++)
			pos_tab[i] = 16'(BASE - 5 * i);
	end

	// Advance the predicted state by one request and return its result
	function automatic res_item_t sequencer_response(input cmd_item_t req);
		res_item_t   r;
		logic [15:0] fire_at;
		logic [16:0] end_at;
		bit          all_done;
		r = '0;
		r.status = ST_OK;
		case (req.command)
			CMD_TICK: begin
				if (run_on) begin
					if (tick_cnt != 16'hFFFF)
						tick_cnt++;
					all_done = 1'b1;
					for (int ch = 0; ch < CHANNELS; ch++) begin
						fire_at = pos_tab[ch] + delay_step * 16'(ch);
						end_at  = {1'b0, fire_at} + 17'(PULSE);
						// a channel timed at zero never fires
						if (fire_at != 16'd0) begin
							if (tick_cnt == fire_at)
								line_lvl[ch] = 1'b0;
							if ({1'b0, tick_cnt} == end_at)
								line_lvl[ch] = 1'b1;
							if ({1'b0, tick_cnt} < end_at)
								all_done = 1'b0;
						end
					end
					// end the run before the chain check
					if (all_done) begin
						run_on   = 1'b0;
						tick_cnt = '0;
					end
					if (tick_cnt >= 16'(CHAIN))
						chain_lvl = 1'b0;
				end
			end
			CMD_EXT_TRIG, CMD_START: begin
				if (req.command == CMD_EXT_TRIG && run_on) begin
					r.status = ST_IGNORED;
				end else begin
					chain_lvl = 1'b1;
					tick_cnt  = '0;
					run_on    = 1'b1;
				end
			end
			CMD_STOP: begin
				run_on   = 1'b0;
				tick_cnt = '0;
			end
			CMD_SET: begin
				if (req.port < CHANNELS)
					pos_tab[req.port[CH_W-1:0]] = 16'(BASE) - req.delay_value;
				else
					r.status = ST_BAD_PORT;
			end
			CMD_GET: begin
				if (req.port < CHANNELS)
					r.read_value = pos_tab[req.port[CH_W-1:0]];
				else
					r.status = ST_BAD_PORT;
			end
			default: ;
		endcase
		r.trigger_lines = line_lvl;
		r.chain_out     = chain_lvl;
		r.running       = run_on;
		return r;
	endfunction

	function automatic cmd_item_t mk_req(input logic [2:0] c, input logic [7:0] p,
		input logic [15:0] v);
		cmd_item_t r;
		r.command     = c;
		r.port        = p;
		r.delay_value = v;
		return r;
	endfunction

	function automatic logic [7:0] rnd_port();
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] rnd_value();
		return 16'($urandom);
	endfunction

	// Offer one request in bursts with random gaps; record its result once taken
	task automatic issue_request(input cmd_item_t req, input bit known = 1'b0,
		input res_item_t want = '0);
		int unsigned gap;
		res_item_t   got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd       <= req;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		got = sequencer_response(req);
		awaited_results.push_back(known ? want : got);
		sent_count++;
	endtask

	// Hold off new requests until every result is back and the pipe is empty
	task automatic wait_all_results();
		cmd_valid  <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_seq_delay(input logic [15:0] v);
		cfg_seq_delay <= v;
		cfg_valid     <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		delay_step = v;
	endtask

	function automatic logic [15:0] pick_position();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return rnd_value();
			default: return 16'($urandom_range(1, 200));
		endcase
	endfunction

	// One run: retime a few channels, start, tick until it ends or hits the cap, mixed with noise
	task automatic play_run(input int max_ticks);
		int          ticks;
		logic [15:0] pos;
		repeat ($urandom_range(0, 4)) begin
			pos = pick_position();
			issue_request(mk_req(CMD_SET, 8'($urandom_range(0, CHANNELS - 1)),
				16'(BASE) - pos));
		end
		issue_request(mk_req(($urandom_range(0, 1) != 0) ? CMD_START : CMD_EXT_TRIG,
			rnd_port(), rnd_value()));
		ticks = 0;
		while (run_on && ticks < max_ticks) begin
			if ($urandom_range(0, 9) != 0) begin
				issue_request(mk_req(CMD_TICK, rnd_port(), rnd_value()));
				ticks++;
			end else begin
				issue_request(mk_req(3'($urandom_range(CMD_EXT_TRIG, CMD_SPARE7)),
					rnd_port(), rnd_value()));
			end
		end
		if (run_on && $urandom_range(0, 1) != 0)
			issue_request(mk_req(CMD_STOP, rnd_port(), rnd_value()));
		repeat ($urandom_range(0, 3))
			issue_request(mk_req(CMD_TICK, rnd_port(), rnd_value()));
		if ($urandom_range(0, 19) == 0)
			wait_all_results();
	endtask

	// Play runs until the phase budget is spent; cap each run by what is left
	task automatic random_phase(input int unsigned count);
		int unsigned goal;
		int unsigned room;
		goal = sent_count + count;
		while (sent_count < goal) begin
			room = goal - sent_count;
			play_run((room > 400) ? 400 : int'(room));
		end
	endtask

	// Receiver: stall pattern changing in stretches, plus one long hold-off
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned stall_mode = 0;
	int unsigned mode_left  = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 250;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       res_ready <= 1'b1;
				1:       res_ready <= ($urandom_range(0, 3) != 0);
				default: res_ready <= ($urandom_range(0, 9) < 4);
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare each delivered result with the oldest outstanding one
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen <= results_seen + 1;
			if (awaited_results.size() == 0) begin
				$error("result delivered with no request outstanding");
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("trigger_lines", want.trigger_lines, res.trigger_lines);
				check_field("chain_out", 16'(want.chain_out), 16'(res.chain_out));
				check_field("running", 16'(want.running), 16'(res.running));
				check_field("status", 16'(want.status), 16'(res.status));
				check_field("read_value", want.read_value, res.read_value);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset delay setting
		for (int i = 0; i < NUM_DIRECTED; i++)
			issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known,
				DIRECTED_ROWS[i].want);

		wait_all_results();
		write_seq_delay(16'd0);
		random_phase(200);

		wait_all_results();
		write_seq_delay(16'hFFFF);
		random_phase(200);

		wait_all_results();
		write_seq_delay(16'($urandom_range(1, 40)));
		random_phase(250);

		wait_all_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
